### sv/ps2mpc_pkg.sv
// Shared types and constants for the PS/2 mouse paint cursor.
`default_nettype none
package ps2mpc_pkg;

   localparam int RX_W      = 8;
   localparam int POS_W     = 17;
   localparam int ADDR_W    = 18;
   localparam int BANK_W    = 3;
   localparam int CAND_W    = 20;
   localparam int Q_DEPTH   = 2;

   localparam int FRAME_WIDTH_DEFAULT  = 320;
   localparam int FRAME_PIXELS_DEFAULT = 76800;
   localparam int START_DEFAULT        = 76799;

   localparam logic [POS_W-1:0] BANK0_TOP = 17'd16383;
   localparam logic [POS_W-1:0] BANK1_TOP = 17'd32766;
   localparam logic [POS_W-1:0] BANK2_TOP = 17'd49149;
   localparam logic [POS_W-1:0] BANK3_TOP = 17'd65532;

   localparam logic [BANK_W-1:0] BANK_0 = 3'd0;
   localparam logic [BANK_W-1:0] BANK_1 = 3'd1;
   localparam logic [BANK_W-1:0] BANK_2 = 3'd2;
   localparam logic [BANK_W-1:0] BANK_3 = 3'd3;
   localparam logic [BANK_W-1:0] BANK_4 = 3'd4;

   localparam logic [1:0] BTN_LEFT  = 2'b01;
   localparam logic [1:0] BTN_RIGHT = 2'b10;
   localparam int         SIGN_X_BIT = 4;
   localparam int         SIGN_Y_BIT = 5;

   typedef enum logic [4:0] {
      PH_SKIP0  = 5'b00001,
      PH_SKIP1  = 5'b00010,
      PH_STATUS = 5'b00100,
      PH_DX     = 5'b01000,
      PH_DY     = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [BANK_W-1:0] bank;
      logic [POS_W-1:0]  base;
      logic              value;
   } packet_type;

endpackage
`default_nettype wire

### sv/ps2mpc_front.sv
// Byte framing, cursor update and packet classification.
`default_nettype none
module ps2mpc_front #(
   parameter int FRAME_WIDTH  = ps2mpc_pkg::FRAME_WIDTH_DEFAULT,
   parameter int FRAME_PIXELS = ps2mpc_pkg::FRAME_PIXELS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            byte_valid,
   input  wire logic [ps2mpc_pkg::RX_W-1:0]     rx_byte,
   input  wire logic                            csr_write_enable,
   input  wire logic [ps2mpc_pkg::POS_W-1:0]    csr_write_data,
   output logic                                 pkt_push,
   output ps2mpc_pkg::packet_type               pkt_data
);
   import ps2mpc_pkg::*;

   localparam int LAST_PIXEL = FRAME_PIXELS - 1;
   localparam int RESET_POS  = (START_DEFAULT > LAST_PIXEL) ? LAST_PIXEL : START_DEFAULT;

   phase_type            phase_ff, phase_in;
   logic [RX_W-1:0]      status_ff, status_in;
   logic [RX_W-1:0]      dx_ff, dx_in;
   logic [POS_W-1:0]     cursor_ff, cursor_in;

   logic [1:0]           buttons;
   logic                 draw;
   logic signed [9:0]    dx9, dy9;
   logic signed [9:0]    qx, qy;
   logic signed [CAND_W-1:0] cand;
   logic                 cand_ok;
   logic [POS_W-1:0]     new_cursor;
   logic [POS_W-1:0]     csr_sat;

   always_comb begin
      buttons = status_ff[1:0];
      draw    = (buttons == BTN_LEFT) || (buttons == BTN_RIGHT);
      dx9 = {status_ff[SIGN_X_BIT], status_ff[SIGN_X_BIT], dx_ff};
      dy9 = {status_ff[SIGN_Y_BIT], status_ff[SIGN_Y_BIT], rx_byte};
      qx  = (dx9 + (dx9[9] ? 10'sd3 : 10'sd0)) >>> 2;
      qy  = (dy9 + (dy9[9] ? 10'sd3 : 10'sd0)) >>> 2;
      cand = signed'(CAND_W'(cursor_ff)) + CAND_W'(qx)
           - CAND_W'(CAND_W'(qy) * signed'(CAND_W'(FRAME_WIDTH)));
      cand_ok = !cand[CAND_W-1] && (cand <= signed'(CAND_W'(LAST_PIXEL)));
      new_cursor = cand_ok ? cand[POS_W-1:0] : cursor_ff;
      csr_sat = (CAND_W'(csr_write_data) > CAND_W'(LAST_PIXEL))
              ? POS_W'(LAST_PIXEL) : csr_write_data;
   end

   always_comb begin
      phase_in  = phase_ff;
      status_in = status_ff;
      dx_in     = dx_ff;
      cursor_in = cursor_ff;
      pkt_push  = 1'b0;
      if (byte_valid) begin
         case (phase_ff)
            PH_SKIP0:  phase_in = PH_SKIP1;
            PH_SKIP1:  phase_in = PH_STATUS;
            PH_STATUS: begin
               status_in = rx_byte;
               phase_in  = PH_DX;
            end
            PH_DX: begin
               dx_in    = rx_byte;
               phase_in = PH_DY;
            end
            PH_DY: begin
               phase_in = PH_STATUS;
               if (draw) begin
                  cursor_in = new_cursor;
                  pkt_push  = 1'b1;
               end
            end
            default:   phase_in = PH_SKIP0;
         endcase
      end
      if (csr_write_enable) begin
         cursor_in = csr_sat;
      end
   end

   always_comb begin
      pkt_data.base  = new_cursor;
      pkt_data.value = (buttons == BTN_RIGHT);
      if (new_cursor <= BANK0_TOP) begin
         pkt_data.bank = BANK_0;
      end else if (new_cursor <= BANK1_TOP) begin
         pkt_data.bank = BANK_1;
      end else if (new_cursor <= BANK2_TOP) begin
         pkt_data.bank = BANK_2;
      end else if (new_cursor <= BANK3_TOP) begin
         pkt_data.bank = BANK_3;
      end else begin
         pkt_data.bank = BANK_4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SKIP0;
         status_ff <= '0;
         dx_ff     <= '0;
         cursor_ff <= POS_W'(RESET_POS);
      end else begin
         phase_ff  <= phase_in;
         status_ff <= status_in;
         dx_ff     <= dx_in;
         cursor_ff <= cursor_in;
      end
   end

endmodule
`default_nettype wire

### sv/ps2mpc_queue.sv
// Short packet queue between the front and the write sequencer.
`default_nettype none
module ps2mpc_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire ps2mpc_pkg::packet_type push_data,
   input  wire logic                   pop,
   output logic                        full,
   output logic                        empty,
   output ps2mpc_pkg::packet_type      head
);
   import ps2mpc_pkg::*;

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   packet_type         slot_ff [Q_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   always_comb begin
      full    = (count_ff == CNT_W'(Q_DEPTH));
      empty   = (count_ff == '0);
      head    = slot_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop  = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

### sv/ps2mpc_back.sv
// Write sequencer: expands one packet into four pixel writes.
`default_nettype none
module ps2mpc_back #(
   parameter int FRAME_WIDTH = ps2mpc_pkg::FRAME_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_empty,
   input  wire ps2mpc_pkg::packet_type        q_head,
   output logic                               q_pop,
   input  wire logic                          rsp_pop,
   output logic                               rsp_empty,
   output logic [ps2mpc_pkg::BANK_W-1:0]      rsp_bank,
   output logic signed [ps2mpc_pkg::ADDR_W-1:0] rsp_pixel_address,
   output logic                               rsp_pixel_value,
   output logic                               rsp_last
);
   import ps2mpc_pkg::*;

   logic [1:0]               step_ff, step_in;
   logic                     valid_ff, valid_in;
   logic [BANK_W-1:0]        bank_ff;
   logic signed [ADDR_W-1:0] addr_ff, addr_in;
   logic                     value_ff;
   logic                     last_ff;
   logic                     load;
   logic signed [ADDR_W-1:0] offset;

   always_comb begin
      load = (!valid_ff || rsp_pop) && !q_empty;
      case (step_ff)
         2'd0:    offset = '0;
         2'd1:    offset = ADDR_W'(1);
         2'd2:    offset = -ADDR_W'(FRAME_WIDTH - 1);
         default: offset = -ADDR_W'(FRAME_WIDTH);
      endcase
      addr_in = signed'(ADDR_W'(q_head.base)) + offset;
      q_pop   = load && (step_ff == 2'd3);
      step_in = load ? step_ff + 2'd1 : step_ff;
      valid_in = load || (valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bank_ff  <= q_head.bank;
         addr_ff  <= addr_in;
         value_ff <= q_head.value;
         last_ff  <= (step_ff == 2'd3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_bank          = bank_ff;
   assign rsp_pixel_address = addr_ff;
   assign rsp_pixel_value   = value_ff;
   assign rsp_last          = last_ff;

endmodule
`default_nettype wire

### sv/ps2_mouse_paint_cursor.sv
// The dy byte queues the packet; its first write then passes to the output register.
// Throughput: one pixel write per cycle while rsp_pop is held, four per drawing packet;
// one byte per cycle while the two-entry packet queue has room, set by the write sequencer.
// Reset: synchronous; drops the next two bytes, empties the queue and output register,
// and loads the cursor with 76799 (clamped to the last pixel of the frame).
`default_nettype none
module ps2_mouse_paint_cursor #(
   parameter int FRAME_WIDTH  = ps2mpc_pkg::FRAME_WIDTH_DEFAULT,
   parameter int FRAME_PIXELS = ps2mpc_pkg::FRAME_PIXELS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic [ps2mpc_pkg::RX_W-1:0]       req_rx_byte,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [ps2mpc_pkg::BANK_W-1:0]          rsp_bank,
   output logic signed [ps2mpc_pkg::ADDR_W-1:0]   rsp_pixel_address,
   output logic                                   rsp_pixel_value,
   output logic                                   rsp_last,
   input  wire logic                              csr_write_enable,
   input  wire logic [ps2mpc_pkg::POS_W-1:0]      csr_write_data
);
   import ps2mpc_pkg::*;

   logic        byte_valid;
   logic        pkt_push;
   packet_type  pkt_data;
   logic        q_full, q_empty, q_pop;
   packet_type  q_head;

   assign req_full   = q_full;
   assign byte_valid = req_push && !q_full;

   ps2mpc_front #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_PIXELS (FRAME_PIXELS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .byte_valid       (byte_valid),
      .rx_byte          (req_rx_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .pkt_push         (pkt_push),
      .pkt_data         (pkt_data)
   );

   ps2mpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (pkt_push),
      .push_data (pkt_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   ps2mpc_back #(
      .FRAME_WIDTH (FRAME_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_bank          (rsp_bank),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_last          (rsp_last)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("output not empty after reset");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      pkt_push |-> !q_full)
      else $error("packet pushed into full queue");

   a_packet_follows: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_last) |=>
      (!rsp_empty && rsp_pixel_value == $past(rsp_pixel_value)
       && rsp_bank == $past(rsp_bank)))
      else $error("packet writes not contiguous");

   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_last)
      else $error("queue popped before fourth write");

endmodule
`default_nettype wire
